@@ rtl/first_fit_allocator_coalescing_unit_macros.svh @@
// Assertion macros for the first-fit allocator.
`ifndef FIRST_FIT_ALLOCATOR_COALESCING_UNIT_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_COALESCING_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FFAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FFAC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define FFAC_ASSERT(lbl, prop, msg)
`define FFAC_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/ffac_pkg.sv @@
// Types and constants shared by the allocator modules.
`default_nettype none
package ffac_pkg;
    localparam int MAX_BLOCKS = 32;
    localparam int FREE_DEPTH = MAX_BLOCKS + 1;
    localparam int ADDR_BITS  = 16;
    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int FIDX_W     = $clog2(FREE_DEPTH);
    localparam int UIDX_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam logic [LEN_W-1:0] MEM_LIMIT = LEN_W'(1) << ADDR_BITS;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [LEN_W-1:0]     request_size;
        logic [ADDR_BITS-1:0] block_start;
    } in_word_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] alloc_addr;
        logic [LEN_W-1:0]     freed_bytes;
        logic [LEN_W-1:0]     used_bytes;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
    } extent_t;

    typedef struct packed {
        logic [LEN_W-1:0] mem_size;
        logic             init;
    } cfg_ctl_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_A_RD, ST_A_CHK, ST_DROP_RD, ST_DROP_WR,
        ST_U_RD, ST_U_CHK, ST_F_RD, ST_F_CHK, ST_DECIDE,
        ST_USH_RD, ST_USH_WR, ST_MERGE, ST_INS_RD, ST_INS_WR
    } state_t;
endpackage
`default_nettype wire

@@ rtl/ffac_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/ffac_apb.sv @@
// APB register port holding memory_size.
`default_nettype none
module ffac_apb import ffac_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_ctl_t         cfg
);
    logic [LEN_W-1:0] mem_size_reg, mem_size_next;
    logic             init_reg;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'd0 || paddr != 2'd0);

    // clamp to 1 .. 2^ADDR_BITS
    always_comb begin
        if (pwdata == 32'd0) begin
            mem_size_next = LEN_W'(1);
        end else if (pwdata > 32'(MEM_LIMIT)) begin
            mem_size_next = MEM_LIMIT;
        end else begin
            mem_size_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg <= MEM_LIMIT;
            init_reg     <= 1'b0;
        end else begin
            init_reg <= wr;
            if (wr) begin
                mem_size_reg <= mem_size_next;
            end
        end
    end

    assign prdata       = 32'(mem_size_reg);
    assign cfg.mem_size = mem_size_reg;
    assign cfg.init     = init_reg;
endmodule
`default_nettype wire

@@ rtl/ffac_engine.sv @@
// Sequencer over the free-extent and used-block memories.
`default_nettype none
`include "first_fit_allocator_coalescing_unit_macros.svh"
module ffac_engine import ffac_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_ctl_t cfg,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_word_t in_data,
    output logic          res_valid,
    input  wire logic     res_ready,
    output out_word_t     res_data
);
    state_t               state_reg, state_next;
    in_word_t             in_reg, in_next;
    logic [FIDX_W-1:0]    idx_reg, idx_next, pos_reg, pos_next, u_reg, u_next;
    logic [CNT_W-1:0]     fc_reg, fc_next, uc_reg, uc_next;
    logic [LEN_W-1:0]     ubytes_reg, ubytes_next, blen_reg, blen_next;
    extent_t              prev_reg, prev_next, cur_reg, cur_next;
    logic                 curv_reg, curv_next, jp_reg, jp_next, jn_reg, jn_next;
    out_word_t            res_reg, res_next;
    logic                 out_pend_reg, out_pend_next;

    logic                 f_we, u_we;
    logic [FIDX_W-1:0]    f_waddr, f_raddr;
    logic [UIDX_W-1:0]    u_waddr, u_raddr;
    extent_t              f_wdata, u_wdata, f_rd, u_rd;
    logic [$bits(extent_t)-1:0] f_rdata, u_rdata;

    logic [CNT_W:0]       idx_inc;
    logic [LEN_W-1:0]     prev_end;
    logic [LEN_W:0]       blk_end;
    logic                 res_stall, alloc_go;

    ffac_ram #(.WIDTH($bits(extent_t)), .DEPTH(FREE_DEPTH)) u_free_ram (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    ffac_ram #(.WIDTH($bits(extent_t)), .DEPTH(MAX_BLOCKS)) u_used_ram (
        .aclk(aclk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(u_raddr), .rdata(u_rdata)
    );

    assign f_rd     = extent_t'(f_rdata);
    assign u_rd     = extent_t'(u_rdata);
    assign idx_inc  = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(1);
    assign prev_end = LEN_W'(prev_reg.start) + prev_reg.len;
    assign blk_end  = (LEN_W+1)'(in_reg.block_start) + (LEN_W+1)'(blen_reg);

    assign in_ready  = (state_reg == ST_IDLE) && !out_pend_reg && !cfg.init;
    assign res_valid = out_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            fc_reg    <= '0;
            uc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            uc_reg    <= uc_next;
        end
        in_reg     <= in_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        u_reg      <= u_next;
        ubytes_reg <= ubytes_next;
        blen_reg   <= blen_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        curv_reg   <= curv_next;
        jp_reg     <= jp_next;
        jn_reg     <= jn_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_pend_reg <= 1'b0;
        end else begin
            out_pend_reg <= out_pend_next;
        end
    end

    always_comb begin
        res_data            = res_reg;
        res_data.used_bytes = ubytes_reg;
    end

    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        u_next        = u_reg;
        fc_next       = fc_reg;
        uc_next       = uc_reg;
        ubytes_next   = ubytes_reg;
        blen_next     = blen_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        curv_next     = curv_reg;
        jp_next       = jp_reg;
        jn_next       = jn_reg;
        res_next      = res_reg;
        out_pend_next = out_pend_reg;
        f_we          = 1'b0;
        f_waddr       = idx_reg;
        f_wdata       = f_rd;
        f_raddr       = idx_reg;
        u_we          = 1'b0;
        u_waddr       = idx_reg[UIDX_W-1:0];
        u_wdata       = u_rd;
        u_raddr       = idx_reg[UIDX_W-1:0];

        case (state_reg)
            ST_INIT: begin
                f_we          = 1'b1;
                f_waddr       = '0;
                f_wdata.start = '0;
                f_wdata.len   = cfg.mem_size;
                fc_next       = CNT_W'(1);
                uc_next       = '0;
                ubytes_next   = '0;
                out_pend_next = 1'b0;
                state_next    = ST_IDLE;
            end
            ST_IDLE: begin
                // hold the finished word until the output register takes it
                if (out_pend_reg && res_ready) begin
                    out_pend_next = 1'b0;
                end
                if (in_valid && in_ready) begin
                    in_next            = in_data;
                    idx_next           = '0;
                    res_next           = '0;
                    res_next.status    = STAT_OK;
                    if (in_data.func == FUNC_FREE) begin
                        if (uc_reg == '0) begin
                            res_next.status = STAT_NOT_FOUND;
                            out_pend_next   = 1'b1;
                        end else begin
                            state_next = ST_U_RD;
                        end
                    end else if (in_data.request_size == '0 || fc_reg == '0) begin
                        res_next.status = STAT_NO_SPACE;
                        out_pend_next   = 1'b1;
                    end else begin
                        state_next = ST_A_RD;
                    end
                end
            end
            ST_A_RD: begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (f_rd.len >= in_reg.request_size) begin
                    if (uc_reg >= CNT_W'(MAX_BLOCKS)) begin
                        res_next.status = STAT_FULL;
                        out_pend_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        u_we                = 1'b1;
                        u_waddr             = uc_reg[UIDX_W-1:0];
                        u_wdata.start       = f_rd.start;
                        u_wdata.len         = in_reg.request_size;
                        uc_next             = uc_reg + CNT_W'(1);
                        ubytes_next         = ubytes_reg + in_reg.request_size;
                        res_next.alloc_addr = f_rd.start;
                        if (f_rd.len == in_reg.request_size) begin
                            state_next = ST_DROP_RD;
                        end else begin
                            f_we          = 1'b1;
                            f_wdata.start = ADDR_BITS'(LEN_W'(f_rd.start)
                                                       + in_reg.request_size);
                            f_wdata.len   = f_rd.len - in_reg.request_size;
                            out_pend_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end else if (idx_inc < (CNT_W+1)'(fc_reg)) begin
                    idx_next   = idx_inc[FIDX_W-1:0];
                    state_next = ST_A_RD;
                end else begin
                    res_next.status = STAT_NO_SPACE;
                    out_pend_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DROP_RD: begin
                // pull the entries above idx down by one
                f_raddr = idx_inc[FIDX_W-1:0];
                if (idx_inc < (CNT_W+1)'(fc_reg)) begin
                    state_next = ST_DROP_WR;
                end else begin
                    fc_next       = fc_reg - CNT_W'(1);
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DROP_WR: begin
                f_we       = 1'b1;
                idx_next   = idx_inc[FIDX_W-1:0];
                state_next = ST_DROP_RD;
            end
            ST_U_RD: begin
                state_next = ST_U_CHK;
            end
            ST_U_CHK: begin
                if (u_rd.start == in_reg.block_start) begin
                    u_next     = idx_reg;
                    blen_next  = u_rd.len;
                    idx_next   = '0;
                    prev_next  = '0;
                    state_next = ST_F_RD;
                end else if (idx_inc < (CNT_W+1)'(uc_reg)) begin
                    idx_next   = idx_inc[FIDX_W-1:0];
                    state_next = ST_U_RD;
                end else begin
                    res_next.status = STAT_NOT_FOUND;
                    out_pend_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_F_RD: begin
                if (CNT_W'(idx_reg) < fc_reg) begin
                    state_next = ST_F_CHK;
                end else begin
                    curv_next  = 1'b0;
                    state_next = ST_DECIDE;
                end
            end
            ST_F_CHK: begin
                if (f_rd.start < in_reg.block_start) begin
                    prev_next  = f_rd;
                    idx_next   = idx_inc[FIDX_W-1:0];
                    state_next = ST_F_RD;
                end else begin
                    cur_next   = f_rd;
                    curv_next  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                jp_next  = (idx_reg != '0) && (prev_end == LEN_W'(in_reg.block_start));
                jn_next  = curv_reg && (blk_end == (LEN_W+1)'(cur_reg.start));
                pos_next = idx_reg;
                if (!jp_next && !jn_next && fc_reg >= CNT_W'(FREE_DEPTH)) begin
                    res_next.status = STAT_FULL;
                    out_pend_next   = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    idx_next   = u_reg;
                    state_next = ST_USH_RD;
                end
            end
            ST_USH_RD: begin
                u_raddr = idx_inc[UIDX_W-1:0];
                if (idx_inc < (CNT_W+1)'(uc_reg)) begin
                    state_next = ST_USH_WR;
                end else begin
                    uc_next    = uc_reg - CNT_W'(1);
                    state_next = ST_MERGE;
                end
            end
            ST_USH_WR: begin
                u_we       = 1'b1;
                idx_next   = idx_inc[FIDX_W-1:0];
                state_next = ST_USH_RD;
            end
            ST_MERGE: begin
                ubytes_next          = ubytes_reg - blen_reg;
                res_next.freed_bytes = blen_reg;
                if (jp_reg) begin
                    f_we          = 1'b1;
                    f_waddr       = pos_reg - FIDX_W'(1);
                    f_wdata.start = prev_reg.start;
                    if (jn_reg) begin
                        f_wdata.len = prev_reg.len + blen_reg + cur_reg.len;
                        idx_next    = pos_reg;
                        state_next  = ST_DROP_RD;
                    end else begin
                        f_wdata.len   = prev_reg.len + blen_reg;
                        out_pend_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (jn_reg) begin
                    f_we          = 1'b1;
                    f_waddr       = pos_reg;
                    f_wdata.start = in_reg.block_start;
                    f_wdata.len   = cur_reg.len + blen_reg;
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    idx_next   = fc_reg[FIDX_W-1:0];
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                // open a slot at pos by pushing entries up
                f_raddr = idx_reg - FIDX_W'(1);
                if (idx_reg > pos_reg) begin
                    state_next = ST_INS_WR;
                end else begin
                    f_we          = 1'b1;
                    f_waddr       = pos_reg;
                    f_wdata.start = in_reg.block_start;
                    f_wdata.len   = blen_reg;
                    fc_next       = fc_reg + CNT_W'(1);
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_INS_WR: begin
                f_we       = 1'b1;
                idx_next   = idx_reg - FIDX_W'(1);
                state_next = ST_INS_RD;
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase

        if (cfg.init) begin
            state_next = ST_INIT;
        end
    end

    assign res_stall = out_pend_reg && !res_ready && !cfg.init;
    assign alloc_go  = in_valid && in_ready && in_data.func == FUNC_ALLOC
                       && in_data.request_size != '0 && fc_reg != '0;

    `FFAC_NEVER(a_fc_bound, fc_reg > CNT_W'(FREE_DEPTH), "free count above table depth")
    `FFAC_NEVER(a_uc_bound, uc_reg > CNT_W'(MAX_BLOCKS), "used count above table depth")
    `FFAC_ASSERT(a_pend_hold, res_stall |=> out_pend_reg, "result dropped")
    `FFAC_ASSERT(a_accept_busy, alloc_go |=> state_reg == ST_A_RD, "allocate did not start")
endmodule
`default_nettype wire

@@ rtl/first_fit_allocator_coalescing_unit.sv @@
// Allocate scans the free extents in order, then shifts free entries down when the chosen
// extent empties; free scans the used blocks, reads free extents to find the insert point,
// shifts used entries down, then shifts free entries down or up as the merge needs.
// A new word is taken in the cycle after the previous result moves to the output
// register; a stalled m_ready holds one word there.
// Reset: ST_INIT writes the first extent; a memory_size write blocks input until it is done.
`default_nettype none
module first_fit_allocator_coalescing_unit import ffac_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_word_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    cfg_ctl_t  cfg;
    logic      eng_ready, res_valid, res_ready;
    out_word_t res_data;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    ffac_apb u_apb (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    ffac_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .in_valid(s_valid), .in_ready(eng_ready), .in_data(s_data),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
    );

    // output register: load a finished word when empty or being drained
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end
    end

    assign res_ready = !m_valid_reg || m_ready;
    assign s_ready   = eng_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

@@ dv/first_fit_allocator_coalescing_unit_tb.sv @@
// Self-checking testbench for the first-fit allocator: predicted results, random traffic.
`default_nettype none
module first_fit_allocator_coalescing_unit_tb;
    import ffac_pkg::*;

    class alloc_scoreboard;
        logic [LEN_W-1:0]     mem_size;
        logic [ADDR_BITS-1:0] fr_start[FREE_DEPTH];
        logic [LEN_W-1:0]     fr_len[FREE_DEPTH];
        int                   fr_cnt;
        logic [ADDR_BITS-1:0] us_start[MAX_BLOCKS];
        logic [LEN_W-1:0]     us_len[MAX_BLOCKS];
        int                   us_cnt;
        out_word_t            pending[$];
        int                   errors;

        function void init_tables(logic [LEN_W-1:0] sz);
            mem_size = sz;
            fr_cnt = 1;
            fr_start[0] = '0;
            fr_len[0] = sz;
            us_cnt = 0;
        endfunction

        function void drop_extent(int idx);
            for (int i = idx; i + 1 < fr_cnt; i++) begin
                fr_start[i] = fr_start[i+1];
                fr_len[i] = fr_len[i+1];
            end
            fr_cnt--;
        endfunction

        function logic [LEN_W-1:0] bytes_in_use();
            logic [LEN_W-1:0] s;
            s = '0;
            for (int i = 0; i < us_cnt; i++) s += us_len[i];
            return s;
        endfunction

        function void note_request(in_word_t w);
            out_word_t r;
            int u, pos;
            bit jp, jn, hit;
            logic [LEN_W-1:0] ln;
            r = '0;
            r.status = STAT_NO_SPACE;
            if (w.func == FUNC_ALLOC) begin
                hit = 0;
                if (w.request_size != 0) begin
                    for (int i = 0; i < fr_cnt && !hit; i++) begin
                        if (fr_len[i] >= w.request_size) begin
                            hit = 1;
                            if (us_cnt >= MAX_BLOCKS) begin
                                r.status = STAT_FULL;
                            end else begin
                                r.status = STAT_OK;
                                r.alloc_addr = fr_start[i];
                                us_start[us_cnt] = fr_start[i];
                                us_len[us_cnt] = w.request_size;
                                us_cnt++;
                                fr_start[i] += w.request_size;
                                fr_len[i] -= w.request_size;
                                if (fr_len[i] == 0) drop_extent(i);
                            end
                        end
                    end
                end
            end else begin
                u = 0;
                while (u < us_cnt && us_start[u] != w.block_start) u++;
                if (u >= us_cnt) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    ln = us_len[u];
                    pos = 0;
                    while (pos < fr_cnt && fr_start[pos] < w.block_start) pos++;
                    jp = pos > 0 && ({1'b0, fr_start[pos-1]} + fr_len[pos-1]
                                     == {1'b0, w.block_start});
                    jn = pos < fr_cnt && ({1'b0, w.block_start} + ln
                                          == {1'b0, fr_start[pos]});
                    if (!jp && !jn && fr_cnt >= FREE_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (int i = u; i + 1 < us_cnt; i++) begin
                            us_start[i] = us_start[i+1];
                            us_len[i] = us_len[i+1];
                        end
                        us_cnt--;
                        if (jp && jn) begin
                            fr_len[pos-1] += ln + fr_len[pos];
                            drop_extent(pos);
                        end else if (jp) begin
                            fr_len[pos-1] += ln;
                        end else if (jn) begin
                            fr_start[pos] = w.block_start;
                            fr_len[pos] += ln;
                        end else begin
                            for (int i = fr_cnt; i > pos; i--) begin
                                fr_start[i] = fr_start[i-1];
                                fr_len[i] = fr_len[i-1];
                            end
                            fr_start[pos] = w.block_start;
                            fr_len[pos] = ln;
                            fr_cnt++;
                        end
                        r.status = STAT_OK;
                        r.freed_bytes = ln;
                    end
                end
            end
            r.used_bytes = bytes_in_use();
            pending.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.alloc_addr !== e.alloc_addr) begin
                $error("alloc_addr exp %0d got %0d", e.alloc_addr, got.alloc_addr); errors++;
            end
            if (got.freed_bytes !== e.freed_bytes) begin
                $error("freed_bytes exp %0d got %0d", e.freed_bytes, got.freed_bytes);
                errors++;
            end
            if (got.used_bytes !== e.used_bytes) begin
                $error("used_bytes exp %0d got %0d", e.used_bytes, got.used_bytes); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_word_t   m_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb = new();
    int  hold_off = 0;
    bit  stall_mode = 0;

    first_fit_allocator_coalescing_unit dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_request(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver: long hold-offs when requested, random stalls in stall mode, else always ready
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else if (stall_mode) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1;
        end
    end

    task automatic write_size(logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
        if (v == 0) v = 1;
        if (v > MEM_LIMIT) v = MEM_LIMIT;
        sb.init_tables(v[LEN_W-1:0]);
        repeat (3) @(posedge aclk);
    endtask

    task automatic send_word(in_word_t w);
        s_valid <= 1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender();
        s_valid <= 0;
    endtask

    task automatic send_alloc(logic [LEN_W-1:0] sz);
        in_word_t w;
        w.func = FUNC_ALLOC;
        w.request_size = sz;
        w.block_start = ADDR_BITS'($urandom);
        send_word(w);
    endtask

    task automatic send_free(logic [ADDR_BITS-1:0] a);
        in_word_t w;
        w.func = FUNC_FREE;
        w.request_size = LEN_W'($urandom);
        w.block_start = a;
        send_word(w);
    endtask

    task automatic drain();
        idle_sender();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // free a random live block, else a random address
    task automatic free_some();
        if (sb.us_cnt > 0 && $urandom_range(0, 9) != 0)
            send_free(sb.us_start[$urandom_range(0, sb.us_cnt - 1)]);
        else
            send_free(ADDR_BITS'($urandom));
    endtask

    task automatic random_phase(int n, int max_sz);
        int burst, gap;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    idle_sender();
                    repeat (gap) @(posedge aclk);
                end
                burst = $urandom_range(1, 12);
            end
            burst--;
            if ($urandom_range(0, 1) == 0 || sb.us_cnt == 0) begin
                case ($urandom_range(0, 9))
                    0: send_alloc(0);
                    1: send_alloc(LEN_W'($urandom_range(0, MEM_LIMIT)));
                    default: send_alloc(LEN_W'($urandom_range(1, max_sz)));
                endcase
            end else begin
                free_some();
            end
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        sb.init_tables(MEM_LIMIT);
        repeat (3) @(posedge aclk);

        // directed: extremes and every error path
        send_alloc(0);
        send_alloc(MEM_LIMIT);
        send_free(16'h0000);
        send_alloc(1);
        send_free(16'hFFFF);
        send_free(16'h0000);
        send_alloc(MEM_LIMIT - 1);
        send_alloc(1);
        send_free(16'h0000);
        drain();
        write_size(32'd0);
        send_alloc(2);
        send_alloc(1);
        send_alloc(1);
        drain();
        write_size(32'h0001_FFFF);
        // fill the used table, then one more for table full
        for (int i = 0; i < MAX_BLOCKS + 1; i++) send_alloc(3);
        // free alternating blocks, then the block between them to merge on both sides
        send_free(16'd3); send_free(16'd9); send_free(16'd6);
        drain();

        stall_mode = 1;
        write_size(32'd64);
        random_phase(150, 16);
        write_size(32'd1000);
        // hold the receiver while the sender keeps offering
        hold_off = 400;
        random_phase(150, 100);
        stall_mode = 0;
        write_size(32'd65536);
        random_phase(150, 8000);
        stall_mode = 1;
        write_size(32'd300);
        random_phase(150, 40);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
